@@ design/aocs_pkg.sv @@
package aocs_pkg;

	// channel configuration
	localparam int CHANNEL_COUNT = 3;
	localparam int NUM_CH        = 3;
	localparam int ACT_CH        = (CHANNEL_COUNT < NUM_CH) ? CHANNEL_COUNT : NUM_CH;
	localparam logic [NUM_CH-1:0] ACT_MASK = NUM_CH'((1 << ACT_CH) - 1);
	localparam int MAX_SAMPLES   = 1024;

	// field widths
	localparam int SUM_W  = 32;
	localparam int CNT_W  = 11;
	localparam int CODE_W = 9;
	localparam int GAIN_W = 5;
	localparam int TGT_W  = 24;
	localparam int IGN_W  = 15;
	localparam int IOFS_W = 27;

	// quotient is only needed below 2^17; larger averages take the overflow path
	localparam int QUO_W = 17;
	localparam int REM_W = CNT_W;
	localparam int BIT_W = 5;

	localparam logic [CODE_W-1:0] CODE_MAX       = 9'h1FF;
	localparam logic [CODE_W-1:0] CODE_BREAK     = 9'h100;
	localparam logic [CODE_W-1:0] DECODE_BASE    = 9'h0FF;
	localparam logic [QUO_W-1:0]  DEFAULT_TARGET = 17'h00080;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_STEP    = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [GAIN_W-1:0] gain_t;

	typedef enum logic [1:0] {
		REG_TARGETS = 2'd0,
		REG_GAINS   = 2'd1,
		REG_EVEN    = 2'd2,
		REG_ODD     = 2'd3
	} reg_idx_t;

	function automatic code_t decode_code(input code_t code);
		return (code < CODE_BREAK) ? code_t'(DECODE_BASE - code) : code;
	endfunction

	function automatic code_t encode_value(input code_t value);
		return (value < CODE_BREAK) ? code_t'(CODE_BREAK - value) : value;
	endfunction

endpackage

@@ design/aocs_in_if.sv @@
interface aocs_in_if import aocs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic              parity;
	logic [SUM_W-1:0]  sum_red;
	logic [SUM_W-1:0]  sum_green;
	logic [SUM_W-1:0]  sum_blue;
	logic [CNT_W-1:0]  samples_used;

	modport source (output valid, cmd, parity, sum_red, sum_green, sum_blue, samples_used,
		input ready);
	modport sink (input valid, cmd, parity, sum_red, sum_green, sum_blue, samples_used,
		output ready);
endinterface

@@ design/aocs_out_if.sv @@
interface aocs_out_if import aocs_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  status;
	logic  changed;
	logic  [1:0] settled_count;
	logic  [1:0] gain_cuts;
	logic  all_ready;
	code_t offset_red;
	code_t offset_green;
	code_t offset_blue;
	gain_t gain_red;
	gain_t gain_green;
	gain_t gain_blue;

	modport source (output valid, status, changed, settled_count, gain_cuts, all_ready,
		offset_red, offset_green, offset_blue, gain_red, gain_green, gain_blue,
		input ready);
	modport sink (input valid, status, changed, settled_count, gain_cuts, all_ready,
		offset_red, offset_green, offset_blue, gain_red, gain_green, gain_blue,
		output ready);
endinterface

@@ design/adc_offset_calibration_step_top.sv @@
// Sequence: restart and rejected items go from idle straight to the finish state; a step item
//   visits each active channel in turn, one load step per ready, all-black or overflowing channel
//   and load, divide and update steps per channel that runs the divider, then finishes.
// Throughput: one item at a time; the next item is taken once the result has been loaded into the
//   output register and the sequencer is back in idle. The 17-step restoring divider is the longest part.
// Reset (arst_n low): config registers, offset codes, gains and ready flags clear to zero.
module adc_offset_calibration_step_top import aocs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	aocs_in_if.sink     in_ch,
	aocs_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	// configuration registers
	logic [TGT_W-1:0]  targets_q;
	logic [IGN_W-1:0]  init_gains_q;
	logic [IOFS_W-1:0] init_even_q;
	logic [IOFS_W-1:0] init_odd_q;

	// calibration state
	code_t             even_code_q [NUM_CH];
	code_t             odd_code_q  [NUM_CH];
	gain_t             gain_q      [NUM_CH];
	logic [NUM_CH-1:0] even_rdy_q;
	logic [NUM_CH-1:0] odd_rdy_q;

	// captured item
	logic [SUM_W-1:0]  sum_q [NUM_CH];
	logic [CNT_W-1:0]  cnt_q;
	logic              parity_q;

	// sequencer and shared divider
	state_t            state_q;
	logic [1:0]        ch_q;
	logic [BIT_W-1:0]  bit_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  div_q;
	logic [QUO_W-1:0]  quo_q;

	// per-item result flags
	logic              status_q;
	logic              changed_q;
	logic [1:0]        settled_q;
	logic [1:0]        cuts_q;
	logic              out_valid_q;

	//------------------------------------------------------------------
	// APB config port: writes complete in the access phase, no wait states
	//------------------------------------------------------------------
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			targets_q    <= '0;
			init_gains_q <= '0;
			init_even_q  <= '0;
			init_odd_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TARGETS: targets_q    <= pwdata[TGT_W-1:0];
				REG_GAINS:   init_gains_q <= pwdata[IGN_W-1:0];
				REG_EVEN:    init_even_q  <= pwdata[IOFS_W-1:0];
				REG_ODD:     init_odd_q   <= pwdata[IOFS_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TARGETS: prdata = {{(32-TGT_W){1'b0}}, targets_q};
			REG_GAINS:   prdata = {{(32-IGN_W){1'b0}}, init_gains_q};
			REG_EVEN:    prdata = {{(32-IOFS_W){1'b0}}, init_even_q};
			REG_ODD:     prdata = {{(32-IOFS_W){1'b0}}, init_odd_q};
			default:     prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Current channel view
	//------------------------------------------------------------------
	logic             in_acc;
	logic             fin_load;
	logic [SUM_W-1:0] cur_sum;
	code_t            cur_code;
	code_t            cur_dec;
	gain_t            cur_gain;
	logic             cur_rdy;
	logic [7:0]       tgt_byte;
	logic [QUO_W-1:0] tgt;
	logic             sum_big;
	logic             below;
	logic [QUO_W-1:0] diff;
	logic             cannot;
	code_t            new_dec;
	code_t            new_enc;
	logic [REM_W+1:0] trial;
	logic             last_ch;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid & in_ch.ready;
	assign fin_load    = (state_q == ST_FIN) & (~out_valid_q | out_ch.ready);

	assign cur_sum  = sum_q[ch_q];
	assign cur_code = parity_q ? odd_code_q[ch_q] : even_code_q[ch_q];
	assign cur_rdy  = parity_q ? odd_rdy_q[ch_q] : even_rdy_q[ch_q];
	assign cur_gain = gain_q[ch_q];
	assign cur_dec  = decode_code(cur_code);
	assign last_ch  = (ch_q == 2'(ACT_CH - 1));

	// target = byte << 8, a zero byte means the default
	assign tgt_byte = targets_q[{ch_q, 3'b000} +: 8];
	assign tgt      = (tgt_byte == 8'd0) ? DEFAULT_TARGET : {1'b0, tgt_byte, 8'h00};

	// (sum*256)/cnt >= 2^17 exactly when sum >= cnt*512: far beyond any target
	assign sum_big = (cur_sum[SUM_W-1:9] >= {{(SUM_W-9-CNT_W){1'b0}}, cnt_q});

	// restoring divider step: shift in next dividend bit, subtract count if it fits
	assign trial = {1'b0, rem_q, div_q[QUO_W-1]} - {2'b00, cnt_q};

	// offset move once the average is known
	assign below   = (quo_q < tgt);
	assign diff    = below ? (tgt - quo_q) : (quo_q - tgt);
	assign cannot  = below ? (({1'b0, diff} + (QUO_W+1)'(cur_dec)) > (QUO_W+1)'(CODE_MAX))
		: (diff > QUO_W'(cur_dec));
	assign new_dec = below ? code_t'(cur_dec + diff[CODE_W-1:0])
		: code_t'(cur_dec - diff[CODE_W-1:0]);
	assign new_enc = encode_value(new_dec);

	// channel action for this cycle
	logic  act_rdy;
	logic  act_code;
	logic  act_cut;
	code_t act_val;
	logic  go_div;

	always_comb begin
		act_rdy  = 1'b0;
		act_code = 1'b0;
		act_cut  = 1'b0;
		act_val  = CODE_MAX;
		go_div   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (!cur_rdy) begin
					if (cur_sum == '0) begin
						// all-black window: push offset to the top code
						if (cur_code == CODE_MAX) act_rdy = 1'b1;
						else act_code = 1'b1;
					end else if (sum_big) begin
						if (cur_gain != '0) act_cut = 1'b1;
						else act_rdy = 1'b1;
					end else begin
						go_div = 1'b1;
					end
				end
			end
			ST_UPD: begin
				if (cannot) begin
					if (cur_gain != '0) act_cut = 1'b1;
					else act_rdy = 1'b1;
				end else if (new_enc != cur_code) begin
					act_code = 1'b1;
					act_val  = new_enc;
				end else begin
					act_rdy = 1'b1;
				end
			end
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer, divider and calibration state
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			quo_q       <= '0;
			status_q    <= STATUS_OK;
			changed_q   <= 1'b0;
			settled_q   <= '0;
			cuts_q      <= '0;
			out_valid_q <= 1'b0;
			even_rdy_q  <= '0;
			odd_rdy_q   <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				even_code_q[i] <= '0;
				odd_code_q[i]  <= '0;
				gain_q[i]      <= '0;
			end
		end else begin
			// result valid: set on load, cleared once taken
			out_valid_q <= fin_load | (out_valid_q & ~out_ch.ready);

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						status_q  <= STATUS_OK;
						changed_q <= 1'b0;
						settled_q <= '0;
						cuts_q    <= '0;
						ch_q      <= '0;
						if (in_ch.cmd == CMD_RESTART) begin
							for (int i = 0; i < NUM_CH; i++) begin
								gain_q[i]      <= init_gains_q[GAIN_W*i +: GAIN_W];
								even_code_q[i] <= init_even_q[CODE_W*i +: CODE_W];
								odd_code_q[i]  <= init_odd_q[CODE_W*i +: CODE_W];
							end
							even_rdy_q <= '0;
							odd_rdy_q  <= '0;
							state_q    <= ST_FIN;
						end else if (in_ch.samples_used == '0 ||
							in_ch.samples_used > CNT_W'(MAX_SAMPLES)) begin
							status_q <= STATUS_REJECT;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					if (go_div) begin
						rem_q   <= cur_sum[9 +: REM_W];
						div_q   <= {cur_sum[8:0], 8'h00};
						quo_q   <= '0;
						bit_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						ch_q    <= last_ch ? ch_q : ch_q + 2'd1;
						state_q <= last_ch ? ST_FIN : ST_LOAD;
					end
				end
				ST_DIV: begin
					rem_q <= trial[REM_W+1] ? {rem_q[REM_W-2:0], div_q[QUO_W-1]}
						: trial[REM_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], ~trial[REM_W+1]};
					div_q <= {div_q[QUO_W-2:0], 1'b0};
					bit_q <= bit_q + 1'b1;
					if (bit_q == BIT_W'(QUO_W - 1)) state_q <= ST_UPD;
				end
				ST_UPD: begin
					ch_q    <= last_ch ? ch_q : ch_q + 2'd1;
					state_q <= last_ch ? ST_FIN : ST_LOAD;
				end
				ST_FIN: begin
					if (fin_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// apply the channel action chosen above
			if (act_rdy) begin
				if (parity_q) odd_rdy_q[ch_q] <= 1'b1;
				else even_rdy_q[ch_q] <= 1'b1;
				settled_q <= settled_q + 2'd1;
			end
			if (act_code) begin
				if (parity_q) odd_code_q[ch_q] <= act_val;
				else even_code_q[ch_q] <= act_val;
				changed_q <= 1'b1;
			end
			if (act_cut) begin
				gain_q[ch_q] <= cur_gain - 1'b1;
				cuts_q       <= cuts_q + 2'd1;
				changed_q    <= 1'b1;
			end
		end
	end

	// item capture and result register: payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			parity_q <= in_ch.parity;
			cnt_q    <= in_ch.samples_used;
			sum_q[0] <= in_ch.sum_red;
			sum_q[1] <= in_ch.sum_green;
			sum_q[2] <= in_ch.sum_blue;
		end
		if (fin_load) begin
			out_ch.status        <= status_q;
			out_ch.changed       <= changed_q;
			out_ch.settled_count <= settled_q;
			out_ch.gain_cuts     <= cuts_q;
			out_ch.all_ready     <= &((even_rdy_q & odd_rdy_q) | ~ACT_MASK);
			out_ch.offset_red    <= ACT_MASK[0] ? (parity_q ? odd_code_q[0] : even_code_q[0]) : '0;
			out_ch.offset_green  <= ACT_MASK[1] ? (parity_q ? odd_code_q[1] : even_code_q[1]) : '0;
			out_ch.offset_blue   <= ACT_MASK[2] ? (parity_q ? odd_code_q[2] : even_code_q[2]) : '0;
			out_ch.gain_red      <= ACT_MASK[0] ? gain_q[0] : '0;
			out_ch.gain_green    <= ACT_MASK[1] ? gain_q[1] : '0;
			out_ch.gain_blue     <= ACT_MASK[2] ? gain_q[2] : '0;
		end
	end

	assign out_ch.valid = out_valid_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	// a finished item waits while the previous result is still pending
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ch.ready)
		|=> (state_q == ST_FIN && $stable(out_ch.status)))
		else $error("result overwritten while pending");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (bit_q < BIT_W'(QUO_W)))
		else $error("divider ran past quotient width");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ((3'(settled_q) + 3'(cuts_q)) <= 3'(ACT_CH)))
		else $error("more channel actions than channels");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.cmd == CMD_STEP && in_ch.samples_used == '0)
		|=> (state_q == ST_FIN && status_q == STATUS_REJECT))
		else $error("empty window not rejected");

endmodule

@@ dv/aocs_calib_monitor.sv @@
module aocs_calib_monitor import aocs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	aocs_in_if          in_mon,
	aocs_out_if         out_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          err_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                          status;
		logic                          changed;
		logic [1:0]                    settled;
		logic [1:0]                    cuts;
		logic                          all_rdy;
		logic [NUM_CH-1:0][CODE_W-1:0] offs;
		logic [NUM_CH-1:0][GAIN_W-1:0] gains;
	} calib_result_t;

	logic [TGT_W-1:0]  targets_q;
	logic [IGN_W-1:0]  init_gains_q;
	logic [IOFS_W-1:0] init_even_q;
	logic [IOFS_W-1:0] init_odd_q;

	// [parity][channel]: 0 even, 1 odd
	code_t codes [2][NUM_CH];
	gain_t gains [NUM_CH];
	logic  rdy   [2][NUM_CH];

	calib_result_t due_results [$];

	function automatic void clear_state();
		targets_q    = '0;
		init_gains_q = '0;
		init_even_q  = '0;
		init_odd_q   = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			gains[ch] = '0;
			for (int p = 0; p < 2; p++) begin
				codes[p][ch] = '0;
				rdy[p][ch]   = 1'b0;
			end
		end
		due_results.delete();
		err_count = 0;
	endfunction

	function automatic calib_result_t advance_calibration(input logic cmd, input logic par,
		input logic [NUM_CH-1:0][SUM_W-1:0] sums, input logic [CNT_W-1:0] cnt);
		calib_result_t res;
		logic [63:0] scaled, avg, tgt, diff, lvl;
		logic below, stuck;
		code_t nxt;
		int settled, cuts, p;
		res     = '0;
		settled = 0;
		cuts    = 0;
		p       = int'(par);
		if (cmd == CMD_RESTART) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				gains[ch]    = init_gains_q[GAIN_W*ch +: GAIN_W];
				codes[0][ch] = init_even_q[CODE_W*ch +: CODE_W];
				codes[1][ch] = init_odd_q[CODE_W*ch +: CODE_W];
				rdy[0][ch]   = 1'b0;
				rdy[1][ch]   = 1'b0;
			end
		end else if (cnt == 0 || cnt > MAX_SAMPLES) begin
			res.status = STATUS_REJECT;
		end else begin
			for (int ch = 0; ch < ACT_CH; ch++) begin
				if (!rdy[p][ch]) begin
					scaled = 64'(sums[ch]) << 8;
					if (scaled == 0) begin
						// all-black window: park at the top code, settle once there
						if (codes[p][ch] != CODE_MAX) begin
							codes[p][ch] = CODE_MAX;
							res.changed  = 1'b1;
						end else begin
							rdy[p][ch] = 1'b1;
							settled++;
						end
					end else begin
						avg = scaled / 64'(cnt);
						tgt = 64'(targets_q[8*ch +: 8]) << 8;
						if (tgt == 0)
							tgt = 64'(DEFAULT_TARGET);
						below = avg < tgt;
						diff  = below ? tgt - avg : avg - tgt;
						lvl   = (codes[p][ch] < CODE_BREAK) ?
							64'(DECODE_BASE) - 64'(codes[p][ch]) : 64'(codes[p][ch]);
						stuck = below ? (lvl + diff > 64'(CODE_MAX)) : (diff > lvl);
						if (stuck) begin
							if (gains[ch] > 0) begin
								gains[ch]   = gains[ch] - 1'b1;
								res.changed = 1'b1;
								cuts++;
							end else begin
								rdy[p][ch] = 1'b1;
								settled++;
							end
						end else begin
							lvl = below ? lvl + diff : lvl - diff;
							nxt = code_t'((lvl < 64'(CODE_BREAK)) ? 64'(CODE_BREAK) - lvl : lvl);
							if (nxt != codes[p][ch]) begin
								codes[p][ch] = nxt;
								res.changed  = 1'b1;
							end else begin
								rdy[p][ch] = 1'b1;
								settled++;
							end
						end
					end
				end
			end
		end
		res.settled = 2'(settled);
		res.cuts    = 2'(cuts);
		res.all_rdy = 1'b1;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (ch < ACT_CH) begin
				if (!rdy[0][ch] || !rdy[1][ch])
					res.all_rdy = 1'b0;
				res.offs[ch]  = codes[p][ch];
				res.gains[ch] = gains[ch];
			end
		end
		return res;
	endfunction

	function automatic void cmp_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		calib_result_t got, want;
		if (!arst_n) begin
			clear_state();
			pending <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got.status   = out_mon.status;
				got.changed  = out_mon.changed;
				got.settled  = out_mon.settled_count;
				got.cuts     = out_mon.gain_cuts;
				got.all_rdy  = out_mon.all_ready;
				got.offs     = {out_mon.offset_blue, out_mon.offset_green, out_mon.offset_red};
				got.gains    = {out_mon.gain_blue, out_mon.gain_green, out_mon.gain_red};
				if (due_results.size() == 0) begin
					$display("%0t ns: result item with nothing expected, actual %0h",
						$time, got);
					err_count++;
				end else begin
					want = due_results.pop_front();
					cmp_field("status", want.status, got.status);
					cmp_field("changed", want.changed, got.changed);
					cmp_field("settled_count", want.settled, got.settled);
					cmp_field("gain_cuts", want.cuts, got.cuts);
					cmp_field("all_ready", want.all_rdy, got.all_rdy);
					for (int ch = 0; ch < NUM_CH; ch++) begin
						cmp_field($sformatf("offset[%0d]", ch), want.offs[ch], got.offs[ch]);
						cmp_field($sformatf("gain[%0d]", ch), want.gains[ch], got.gains[ch]);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_TARGETS: targets_q    = pwdata[TGT_W-1:0];
					REG_GAINS:   init_gains_q = pwdata[IGN_W-1:0];
					REG_EVEN:    init_even_q  = pwdata[IOFS_W-1:0];
					REG_ODD:     init_odd_q   = pwdata[IOFS_W-1:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				due_results.push_back(advance_calibration(in_mon.cmd, in_mon.parity,
					{in_mon.sum_blue, in_mon.sum_green, in_mon.sum_red}, in_mon.samples_used));
			pending <= due_results.size();
		end
	end

endmodule

@@ dv/adc_offset_calibration_step_top_tb.sv @@
module adc_offset_calibration_step_top_tb;
	import aocs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int HOLD_CYCLES     = 300;  // long output stall, fills the block
	localparam int DRAIN_CYCLES    = 64;   // covers the worst case step

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          err_count;
	int          pending;

	// handshakes between the item source and the result sink
	bit hold_req;
	bit idle_on;
	bit calm;

	// stimulus-side copy of the targets, used to aim sums near convergence
	logic [TGT_W-1:0] cur_targets;

	aocs_in_if  in_bus ();
	aocs_out_if out_bus ();

	adc_offset_calibration_step_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_bus),
		.out_ch  (out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	aocs_calib_monitor u_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_bus),
		.out_mon   (out_bus),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.err_count (err_count),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop, far above the slowest correct run
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Result sink: random short stalls, one long hold-off on request, none when calm.
	initial begin
		int stall_left;
		int hold_left;
		logic rdy;
		stall_left    = 0;
		hold_left     = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				rdy        = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_bus.ready <= rdy;
		end
	end

	// APB write: setup cycle, then access cycle until pready
	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input logic [TGT_W-1:0] tg, input logic [IGN_W-1:0] gn,
		input logic [IOFS_W-1:0] ev, input logic [IOFS_W-1:0] od);
		cur_targets = tg;
		reg_write(REG_TARGETS, 32'(tg));
		reg_write(REG_GAINS, 32'(gn));
		reg_write(REG_EVEN, 32'(ev));
		reg_write(REG_ODD, 32'(od));
	endtask

	// Offer one item, optionally after a short gap, and wait until it is taken.
	task automatic offer(input logic c, input logic par, input logic [SUM_W-1:0] s0,
		input logic [SUM_W-1:0] s1, input logic [SUM_W-1:0] s2, input logic [CNT_W-1:0] cnt);
		int gap;
		gap = (!calm && idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.cmd          <= c;
		in_bus.parity       <= par;
		in_bus.sum_red      <= s0;
		in_bus.sum_green    <= s1;
		in_bus.sum_blue     <= s2;
		in_bus.samples_used <= cnt;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Stop offering and wait until every expected result is back, then let the block idle.
	task automatic settle();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sum whose average lands within about +-spread of the channel target.
	function automatic logic [SUM_W-1:0] near_sum(input int ch, input logic [CNT_W-1:0] cnt,
		input int spread);
		longint t, m, s;
		t = longint'(cur_targets[8*ch +: 8]) << 8;
		if (t == 0)
			t = longint'(DEFAULT_TARGET);
		m = (longint'(spread) * cnt) / 256 + 1;
		s = (t * cnt) / 256 + longint'($urandom_range(0, int'(2 * m))) - m;
		if (s < 0)
			s = 0;
		if (s > 64'hFFFF_FFFF)
			s = 64'hFFFF_FFFF;
		return SUM_W'(s);
	endfunction

	initial begin
		int sent;
		int len;
		int black_pct;
		int wild_pct;
		int k;
		int spread;
		bit hold_done;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] s [NUM_CH];
		logic [TGT_W-1:0] tg;
		logic [IGN_W-1:0] gn;
		logic [IOFS_W-1:0] ev;
		logic [IOFS_W-1:0] od;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_bus.valid        = 1'b0;
		in_bus.cmd          = CMD_RESTART;
		in_bus.parity       = 1'b0;
		in_bus.sum_red      = '0;
		in_bus.sum_green    = '0;
		in_bus.sum_blue     = '0;
		in_bus.samples_used = '0;
		hold_req            = 1'b0;
		idle_on             = 1'b1;
		calm                = 1'b0;
		hold_done           = 1'b0;
		cur_targets         = '0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// --- directed part ---
		// steps on the reset state: all-black on zero codes, then overflow with zero gain
		offer(CMD_STEP, 1'b0, 32'd0, 32'd0, 32'd0, 11'd1);
		offer(CMD_STEP, 1'b1, '1, '1, '1, 11'd1024);
		settle();

		// targets 0x0100 / default 0x80 / 0xFF00; gains 1 / 31 / 0
		load_settings(24'hFF_00_01, {5'd0, 5'd31, 5'd1}, {9'h1FF, 9'h000, 9'h0FF},
			{9'h100, 9'h080, 9'h1FE});
		offer(CMD_RESTART, 1'b0, '1, '1, '1, '1);
		offer(CMD_RESTART, 1'b1, '0, '0, '0, '0);
		// empty and oversized windows are rejected
		offer(CMD_STEP, 1'b0, 32'd100, 32'd100, 32'd100, 11'd0);
		offer(CMD_STEP, 1'b1, 32'd100, 32'd100, 32'd100, 11'd1025);
		offer(CMD_STEP, 1'b0, '1, '1, '1, '1);
		// all-black twice: move to the top code, then settle
		offer(CMD_STEP, 1'b0, 32'd0, 32'd0, 32'd0, 11'd1);
		offer(CMD_STEP, 1'b0, 32'd0, 32'd0, 32'd0, 11'd5);
		// far above target: gain cut, or settle at zero gain
		offer(CMD_STEP, 1'b1, '1, '1, '1, 11'd1);
		// far below target: offset moves up, or cannot reach
		offer(CMD_STEP, 1'b1, 32'd1, 32'd1, 32'd1, 11'd1024);
		// exactly on target: codes creep or stop, channels settle
		repeat (4)
			offer(CMD_STEP, 1'b1, 32'd1024, 32'd512, 32'd261120, 11'd1024);
		offer(CMD_STEP, 1'b1, 32'd1, 32'd0, 32'd255, 11'd1);
		offer(CMD_STEP, 1'b1, 32'd0, 32'd0, 32'd0, 11'd1);
		offer(CMD_STEP, 1'b1, 32'd0, 32'd0, 32'd0, 11'd1);
		// restart clears every ready flag
		offer(CMD_RESTART, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 11'h555);
		offer(CMD_STEP, 1'b0, 32'd1100, 32'd490, 32'd260000, 11'd1024);
		offer(CMD_STEP, 1'b1, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 11'd1000);
		settle();

		// --- random part ---
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					tg = '0;
					gn = '0;
					ev = '0;
					od = '0;
				end
				1: begin
					tg = '1;
					gn = '1;
					ev = '1;
					od = '1;
				end
				default: begin
					tg = TGT_W'($urandom);
					gn = IGN_W'($urandom);
					ev = IOFS_W'($urandom);
					od = IOFS_W'($urandom);
					// keep gains low in some phases so channels settle fast
					if ($urandom_range(0, 1) == 0)
						gn = gn & {NUM_CH{5'b00011}};
				end
			endcase
			load_settings(tg, gn, ev, od);
			calm = (ph == PHASES - 1);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				idle_on = !calm && ($urandom_range(0, 3) != 0);
				// one long output hold-off while items keep coming
				if (ph == 3 && sent >= 40 && !hold_done) begin
					hold_req  = 1'b1;
					hold_done = 1'b1;
				end
				if ($urandom_range(0, 99) < 85) begin
					// calibration run: restart, then a series of steps
					offer(CMD_RESTART, 1'($urandom), $urandom, $urandom, $urandom,
						CNT_W'($urandom));
					sent++;
					len       = $urandom_range(4, 40);
					black_pct = $urandom_range(0, 25);
					wild_pct  = $urandom_range(0, 12);
					repeat (len) begin
						k = $urandom_range(0, 9);
						if (k < 2)
							cnt = CNT_W'($urandom_range(1, 16));
						else if (k == 2)
							cnt = CNT_W'(MAX_SAMPLES);
						else
							cnt = CNT_W'($urandom_range(1, MAX_SAMPLES));
						// an occasional broken window inside the run
						if ($urandom_range(0, 49) == 0)
							cnt = ($urandom_range(0, 1) == 0) ? '0 :
								CNT_W'($urandom_range(MAX_SAMPLES + 1, 2047));
						for (int ch = 0; ch < NUM_CH; ch++) begin
							k = $urandom_range(0, 99);
							case ($urandom_range(0, 4))
								0: spread = 0;
								1: spread = 2;
								2: spread = 16;
								3: spread = 128;
								default: spread = 400;
							endcase
							if (k < black_pct)
								s[ch] = '0;
							else if (k < black_pct + wild_pct)
								s[ch] = $urandom;
							else
								s[ch] = near_sum(ch, cnt, spread);
						end
						offer(CMD_STEP, 1'($urandom), s[0], s[1], s[2], cnt);
						sent++;
					end
				end else begin
					// noise: any command, any count, any sums
					repeat ($urandom_range(1, 6)) begin
						cnt = ($urandom_range(0, 7) == 0) ? '0 : CNT_W'($urandom);
						offer(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, cnt);
						sent++;
					end
				end
			end
			// sender pauses here until all results are back
			settle();
		end

		if (err_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
